// ===== rtl/alla_pkg.sv =====
`timescale 1ns / 1ps

package alla_pkg;

   localparam int NUM_WORKERS = 16;
   localparam int NUM_JOBS    = 64;
   localparam int WORKER_BITS = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
   localparam int JOB_BITS    = 6;
   localparam int LOAD_BITS   = 7;
   localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};

   typedef struct packed {
      logic [JOB_BITS-1:0] job_index;
      logic [15:0]         free_worker_mask;
   } alla_req_type;

   typedef struct packed {
      logic [3:0] worker_rank;
      logic       newly_assigned;
      logic       had_prior_assignment;
      logic       no_free_worker;
   } alla_rsp_type;

endpackage

// ===== rtl/affinity_least_loaded_assigner.sv =====
`timescale 1ns / 1ps
// A transaction accepted on start goes through S_SCAN and S_DONE, then rsp_valid is set.
// One transaction at a time: a new start is not taken while busy; a serial scan visits
// one worker per cycle, sharing a single load comparator.
// busy is low while the result is shown, so the next start may be taken in that cycle.
// Synchronous reset clears the job rows (through per-row valid bits) and all worker loads.
// The result is held for one cycle only; the receiver cannot stall it.
module affinity_least_loaded_assigner (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  alla_pkg::alla_req_type req_data,
   output logic                  rsp_valid,
   output alla_pkg::alla_rsp_type rsp_data
);
   import alla_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;
   localparam logic [WORKER_BITS-1:0] LAST_IDX = WORKER_BITS'(NUM_WORKERS - 1);

   logic [1:0]             state_ff, state_in;
   logic [WORKER_BITS-1:0] idx_ff, idx_in;
   logic [JOB_BITS-1:0]    job_ff;
   logic [NUM_WORKERS-1:0] mask_ff;
   logic [NUM_WORKERS-1:0] mem [NUM_JOBS];
   logic [NUM_WORKERS-1:0] mem_q_ff;
   logic                   row_valid_q_ff;
   logic [NUM_JOBS-1:0]    row_valid_ff;
   logic [LOAD_BITS-1:0]   load_ff [NUM_WORKERS];
   logic                   found_ff, found_in;
   logic [LOAD_BITS-1:0]   best_ff, best_in;
   logic [WORKER_BITS-1:0] best_rank_ff, best_rank_in;
   logic                   hit_found_ff, hit_found_in;
   logic [WORKER_BITS-1:0] hit_rank_ff, hit_rank_in;
   logic                   rsp_valid_ff;
   alla_rsp_type           rsp_ff;

   logic [NUM_WORKERS-1:0] row;
   logic                   accept;
   logic                   none;
   logic                   assign_new;
   logic [WORKER_BITS-1:0] chosen;

   assign accept     = start && (state_ff == S_IDLE);
   assign row        = row_valid_q_ff ? mem_q_ff : '0;
   assign none       = (mask_ff == '0);
   assign assign_new = (state_ff == S_DONE) && !none && !hit_found_ff;
   assign chosen     = hit_found_ff ? hit_rank_ff : best_rank_ff;

   // Sequencer and the shared compare step of the scan.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_rank_in = best_rank_ff;
      hit_found_in = hit_found_ff;
      hit_rank_in  = hit_rank_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in     = S_SCAN;
               idx_in       = '0;
               found_in     = 1'b0;
               hit_found_in = 1'b0;
            end
         end
         S_SCAN: begin
            if (mask_ff[idx_ff] && row[idx_ff] && !hit_found_ff) begin
               hit_found_in = 1'b1;
               hit_rank_in  = idx_ff;
            end
            // Strict less-than keeps the lowest rank on equal loads.
            if (mask_ff[idx_ff] && (!found_ff || load_ff[idx_ff] < best_ff)) begin
               found_in     = 1'b1;
               best_in      = load_ff[idx_ff];
               best_rank_in = idx_ff;
            end
            if (idx_ff == LAST_IDX) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
         for (int i = 0; i < NUM_WORKERS; i++) begin
            load_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_DONE);
         if (assign_new) begin
            row_valid_ff[job_ff] <= 1'b1;
            if (load_ff[best_rank_ff] != LOAD_MAX) begin
               load_ff[best_rank_ff] <= load_ff[best_rank_ff] + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      best_rank_ff <= best_rank_in;
      hit_found_ff <= hit_found_in;
      hit_rank_ff  <= hit_rank_in;
      if (accept) begin
         job_ff         <= req_data.job_index;
         mask_ff        <= req_data.free_worker_mask[NUM_WORKERS-1:0];
         row_valid_q_ff <= row_valid_ff[req_data.job_index];
      end
      if (state_ff == S_DONE) begin
         rsp_ff.worker_rank          <= none ? 4'd0 : 4'(chosen);
         rsp_ff.newly_assigned       <= assign_new;
         rsp_ff.had_prior_assignment <= (row != '0);
         rsp_ff.no_free_worker       <= none;
      end
   end

   // Job row store: one read on acceptance, one write when a new assignment is made.
   always_ff @(posedge clock) begin
      if (assign_new) begin
         mem[job_ff] <= row | (NUM_WORKERS'(1) << best_rank_ff);
      end
      if (accept) begin
         mem_q_ff <= mem[req_data.job_index];
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while a transaction is still in progress");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not start the scan");

   a_empty_no_change: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.no_free_worker) |-> !rsp_data.newly_assigned)
      else $error("assignment recorded with no free worker");

   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && $past(state_ff) == S_IDLE) |-> (idx_ff == '0))
      else $error("scan did not begin at rank zero");

   a_new_is_fresh: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.newly_assigned) |-> !$past(hit_found_ff, 2))
      else $error("new assignment recorded although the job already held a free worker");

endmodule
